### rtl/core/ectc_pkg.sv
// Shared types and constants for the eight-bit timer/compare unit.
package ectc_pkg;

  localparam int DEF_MAX_DIVIDER = 1024;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_e;

  localparam logic [2:0] REG_CTRL_A  = 3'd0;
  localparam logic [2:0] REG_CTRL_B  = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_CMP_A   = 3'd3;
  localparam logic [2:0] REG_CMP_B   = 3'd4;
  localparam logic [2:0] REG_MASK    = 3'd5;
  localparam logic [2:0] REG_FLAGS   = 3'd6;

  localparam logic [1:0] ACK_CMP_A   = 2'd0;
  localparam logic [1:0] ACK_CMP_B   = 2'd1;
  localparam logic [1:0] ACK_OVF     = 2'd2;

  // Flag bit positions
  localparam int FLAG_TOV  = 0;
  localparam int FLAG_OCFA = 1;
  localparam int FLAG_OCFB = 2;

  // Waveform modes: {control_b[3], control_a[1:0]}
  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_PWM_PC     = 3'd1;
  localparam logic [2:0] MODE_CTC        = 3'd2;
  localparam logic [2:0] MODE_FAST_PWM   = 3'd3;
  localparam logic [2:0] MODE_FROZEN_LO  = 3'd4;
  localparam logic [2:0] MODE_PC_TOP_A   = 3'd5;
  localparam logic [2:0] MODE_FROZEN_HI  = 3'd6;

  // Clock select codes
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;

  typedef struct packed {
    cmd_e        command;
    logic [2:0]  register_index;
    logic [7:0]  write_data;
    logic [1:0]  ack_source;
  } ectc_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_compare_a;
    logic        irq_compare_b;
    logic        irq_overflow;
  } ectc_result_t;

endpackage

### rtl/core/ectc_timer.sv
// Timer state registers with the per-beat register access and counter step logic.
module ectc_timer #(
  parameter int MAX_DIVIDER = ectc_pkg::DEF_MAX_DIVIDER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  ectc_pkg::ectc_item_t  item,
  output ectc_pkg::ectc_result_t result
);
  import ectc_pkg::*;

  localparam int PW = $clog2(MAX_DIVIDER);

  logic [7:0]  ctrl_a_r, ctrl_a_nxt;
  logic [7:0]  ctrl_b_r, ctrl_b_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  cmp_a_r, cmp_a_nxt;
  logic [7:0]  cmp_b_r, cmp_b_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [PW-1:0] presc_r, presc_nxt;

  logic [2:0]  mode;
  logic [2:0]  cs;
  logic [PW:0] divider;
  logic [PW:0] presc_inc;
  logic [7:0]  top_val;
  logic [7:0]  tov_at;
  logic [7:0]  rd;

  assign mode      = {ctrl_b_r[3], ctrl_a_r[1:0]};
  assign cs        = ctrl_b_r[2:0];
  assign presc_inc = {1'b0, presc_r} + (PW+1)'(1);

  always_comb begin
    case (cs)
      CS_DIV1:   divider = (PW+1)'(1);
      CS_DIV8:   divider = (PW+1)'(8);
      CS_DIV64:  divider = (PW+1)'(64);
      CS_DIV256: divider = (PW+1)'(256);
      default:   divider = (PW+1)'(MAX_DIVIDER);
    endcase
  end

  always_comb begin
    case (mode)
      MODE_NORMAL, MODE_FAST_PWM: begin
        top_val = 8'hff;
        tov_at  = 8'hff;
      end
      MODE_PWM_PC: begin
        top_val = 8'hff;
        tov_at  = 8'h00;
      end
      MODE_CTC: begin
        top_val = cmp_a_r;
        tov_at  = 8'hff;
      end
      MODE_PC_TOP_A: begin
        top_val = cmp_a_r;
        tov_at  = 8'h00;
      end
      default: begin
        top_val = cmp_a_r;
        tov_at  = cmp_a_r;
      end
    endcase
  end

  always_comb begin
    ctrl_a_nxt = ctrl_a_r;
    ctrl_b_nxt = ctrl_b_r;
    count_nxt  = count_r;
    cmp_a_nxt  = cmp_a_r;
    cmp_b_nxt  = cmp_b_r;
    mask_nxt   = mask_r;
    flags_nxt  = flags_r;
    presc_nxt  = presc_r;
    rd         = 8'h00;
    case (item.command)
      CMD_TICK: begin
        if (mode != MODE_FROZEN_LO && mode != MODE_FROZEN_HI && cs != CS_STOP) begin
          if (presc_inc >= divider) begin
            presc_nxt = '0;
            // Flags fire on leaving the matching count
            if (count_r == cmp_a_r) flags_nxt[FLAG_OCFA] = 1'b1;
            if (count_r == cmp_b_r) flags_nxt[FLAG_OCFB] = 1'b1;
            if (count_r == tov_at)  flags_nxt[FLAG_TOV]  = 1'b1;
            if (count_r == top_val || count_r == 8'hff) count_nxt = 8'h00;
            else count_nxt = count_r + 8'd1;
          end else begin
            presc_nxt = presc_inc[PW-1:0];
          end
        end
      end
      CMD_READ: begin
        case (item.register_index)
          REG_CTRL_A: rd = ctrl_a_r;
          REG_CTRL_B: rd = ctrl_b_r;
          REG_COUNT:  rd = count_r;
          REG_CMP_A:  rd = cmp_a_r;
          REG_CMP_B:  rd = cmp_b_r;
          REG_MASK:   rd = mask_r;
          REG_FLAGS:  rd = {5'd0, flags_r};
          default:    rd = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        case (item.register_index)
          REG_CTRL_A: ctrl_a_nxt = item.write_data;
          REG_CTRL_B: ctrl_b_nxt = item.write_data;
          REG_COUNT:  count_nxt  = item.write_data;
          REG_CMP_A:  cmp_a_nxt  = item.write_data;
          REG_CMP_B:  cmp_b_nxt  = item.write_data;
          REG_MASK:   mask_nxt   = item.write_data;
          // Write one to clear
          REG_FLAGS:  flags_nxt  = flags_r & ~item.write_data[2:0];
          default:    ;
        endcase
      end
      default: begin
        case (item.ack_source)
          ACK_CMP_A: flags_nxt[FLAG_OCFA] = 1'b0;
          ACK_CMP_B: flags_nxt[FLAG_OCFB] = 1'b0;
          ACK_OVF:   flags_nxt[FLAG_TOV]  = 1'b0;
          default:   ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r <= '0;
      ctrl_b_r <= '0;
      count_r  <= '0;
      cmp_a_r  <= '0;
      cmp_b_r  <= '0;
      mask_r   <= '0;
      flags_r  <= '0;
      presc_r  <= '0;
    end else if (step_en) begin
      ctrl_a_r <= ctrl_a_nxt;
      ctrl_b_r <= ctrl_b_nxt;
      count_r  <= count_nxt;
      cmp_a_r  <= cmp_a_nxt;
      cmp_b_r  <= cmp_b_nxt;
      mask_r   <= mask_nxt;
      flags_r  <= flags_nxt;
      presc_r  <= presc_nxt;
    end
  end

  // Interrupt lines reflect the state after this beat
  assign result.read_data     = rd;
  assign result.irq_compare_a = flags_nxt[FLAG_OCFA] & mask_nxt[FLAG_OCFA];
  assign result.irq_compare_b = flags_nxt[FLAG_OCFB] & mask_nxt[FLAG_OCFB];
  assign result.irq_overflow  = flags_nxt[FLAG_TOV]  & mask_nxt[FLAG_TOV];

endmodule

### rtl/core/eight_bit_timer_compare_unit.sv
// Top level of the eight-bit timer/compare unit: input register, timer, result register.
//
//   channel | dir | tdata fields (lsb up)                                   | tuser
//   in_     | in  | register_index[2:0] write_data[10:3] ack_source[12:11]   | command[1:0]
//   out_    | out | read_data[7:0] irq_compare_a[8] irq_compare_b[9]         | -
//           |     | irq_overflow[10]                                        |
//
// One beat in and one beat out per cycle while out_ does not stall; each beat waits in the input
// register and leaves through the result register.
// The timer state is updated as a beat moves from the input to the result register.
// Synchronous active-low reset clears both valid flags and all timer registers.
// A stall on out_ holds the result; in_ keeps taking a beat until both registers fill.
module eight_bit_timer_compare_unit #(
  parameter int MAX_DIVIDER = ectc_pkg::DEF_MAX_DIVIDER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // register_index, write_data, ack_source, zero pad
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data, irq_compare_a, irq_compare_b, irq_overflow, pad
);
  import ectc_pkg::*;

  logic          in_valid_r;
  ectc_item_t    item_r;
  logic          out_valid_r;
  ectc_result_t  res_r;
  ectc_result_t  res_nxt;
  logic          advance;
  logic          in_acc;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || advance);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.command        <= cmd_e'(in_tuser);
      item_r.register_index <= in_tdata[2:0];
      item_r.write_data     <= in_tdata[10:3];
      item_r.ack_source     <= in_tdata[12:11];
    end
    if (advance) res_r <= res_nxt;
  end

  ectc_timer #(
    .MAX_DIVIDER (MAX_DIVIDER)
  ) u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .result  (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.irq_overflow, res_r.irq_compare_b, res_r.irq_compare_a,
                       res_r.read_data};

endmodule

### rtl/core/ectc_checker.sv
// Port-level checks for the eight-bit timer/compare unit and their binding.
module ectc_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:11] == 5'd0)
    else $error("result padding not zero");

  // Input may only stall behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind eight_bit_timer_compare_unit ectc_port_checks u_ectc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/ectc_checker.sv
// Checker for the eight-bit timer/compare unit: predicts each result beat and compares it.
`timescale 1ns / 100ps
module ectc_checker #(
  parameter int MAX_DIVIDER = ectc_pkg::DEF_MAX_DIVIDER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // register_index, write_data, ack_source, zero pad
  input  logic [1:0]  in_tuser,   // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // read_data, irq_compare_a, irq_compare_b, irq_overflow, pad
  output int          error_count,
  output int          results_owed
);
  import ectc_pkg::*;

  // Shadow copy of the timer registers
  logic [7:0]   ctrl_a, ctrl_b, count, cmp_a, cmp_b, mask;
  logic [2:0]   flags;
  int unsigned  prescale;

  ectc_result_t owed_results[$];
  ectc_item_t   seen_beat;
  ectc_result_t got, want;

  function automatic void advance_count(logic [2:0] mode);
    logic [7:0] top, ovf_at;
    case (mode)
      MODE_NORMAL, MODE_FAST_PWM: begin
        top = 8'hff;
        ovf_at = 8'hff;
      end
      MODE_PWM_PC: begin
        top = 8'hff;
        ovf_at = 8'h00;
      end
      MODE_CTC: begin
        top = cmp_a;
        ovf_at = 8'hff;
      end
      MODE_PC_TOP_A: begin
        top = cmp_a;
        ovf_at = 8'h00;
      end
      default: begin
        top = cmp_a;
        ovf_at = cmp_a;
      end
    endcase
    // flags are raised on leaving the matching value
    if (count == cmp_a) flags[FLAG_OCFA] = 1'b1;
    if (count == cmp_b) flags[FLAG_OCFB] = 1'b1;
    if (count == ovf_at) flags[FLAG_TOV] = 1'b1;
    // above TOP the count runs on to 255 before wrapping
    count = (count == top || count == 8'hff) ? 8'h00 : count + 8'd1;
  endfunction

  function automatic ectc_result_t apply_timer_beat(ectc_item_t beat);
    logic [2:0]   mode, clk_sel;
    int unsigned  divider;
    ectc_result_t res;
    res = '0;
    mode = {ctrl_b[3], ctrl_a[1:0]};
    clk_sel = ctrl_b[2:0];
    case (beat.command)
      CMD_TICK: begin
        if (mode != MODE_FROZEN_LO && mode != MODE_FROZEN_HI && clk_sel != CS_STOP) begin
          case (clk_sel)
            CS_DIV1:   divider = 1;
            CS_DIV8:   divider = 8;
            CS_DIV64:  divider = 64;
            CS_DIV256: divider = 256;
            default:   divider = MAX_DIVIDER;
          endcase
          // a prescaler already past a lowered divider wraps at once
          if (prescale + 1 >= divider) begin
            prescale = 0;
            advance_count(mode);
          end else begin
            prescale++;
          end
        end
      end
      CMD_READ: begin
        case (beat.register_index)
          REG_CTRL_A: res.read_data = ctrl_a;
          REG_CTRL_B: res.read_data = ctrl_b;
          REG_COUNT:  res.read_data = count;
          REG_CMP_A:  res.read_data = cmp_a;
          REG_CMP_B:  res.read_data = cmp_b;
          REG_MASK:   res.read_data = mask;
          REG_FLAGS:  res.read_data = {5'b00000, flags};
          default:    res.read_data = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        case (beat.register_index)
          REG_CTRL_A: ctrl_a = beat.write_data;
          REG_CTRL_B: ctrl_b = beat.write_data;
          REG_COUNT:  count = beat.write_data;
          REG_CMP_A:  cmp_a = beat.write_data;
          REG_CMP_B:  cmp_b = beat.write_data;
          REG_MASK:   mask = beat.write_data;
          REG_FLAGS:  flags = flags & ~beat.write_data[2:0];
          default:    ;
        endcase
      end
      CMD_ACK: begin
        case (beat.ack_source)
          ACK_CMP_A: flags[FLAG_OCFA] = 1'b0;
          ACK_CMP_B: flags[FLAG_OCFB] = 1'b0;
          ACK_OVF:   flags[FLAG_TOV] = 1'b0;
          default:   ;
        endcase
      end
    endcase
    res.irq_compare_a = flags[FLAG_OCFA] & mask[FLAG_OCFA];
    res.irq_compare_b = flags[FLAG_OCFB] & mask[FLAG_OCFB];
    res.irq_overflow  = flags[FLAG_TOV] & mask[FLAG_TOV];
    return res;
  endfunction

  function automatic void check_field(string field, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %02h, actual %02h", $time, field, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a = '0;
      ctrl_b = '0;
      count = '0;
      cmp_a = '0;
      cmp_b = '0;
      mask = '0;
      flags = '0;
      prescale = 0;
      owed_results.delete();
    end else begin
      // retire the result beat before taking the new input beat
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[7:0];
        got.irq_compare_a = out_tdata[8];
        got.irq_compare_b = out_tdata[9];
        got.irq_overflow = out_tdata[10];
        if (owed_results.size() == 0) begin
          $display("%0t: result beat %04h arrived with nothing expected", $time, out_tdata);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_compare_a", 8'(want.irq_compare_a), 8'(got.irq_compare_a));
          check_field("irq_compare_b", 8'(want.irq_compare_b), 8'(got.irq_compare_b));
          check_field("irq_overflow", 8'(want.irq_overflow), 8'(got.irq_overflow));
        end
      end
      if (in_tvalid && in_tready) begin
        seen_beat.command = cmd_e'(in_tuser);
        seen_beat.register_index = in_tdata[2:0];
        seen_beat.write_data = in_tdata[10:3];
        seen_beat.ack_source = in_tdata[12:11];
        owed_results.push_back(apply_timer_beat(seen_beat));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

### test/tb.sv
// Testbench top for the eight-bit timer/compare unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import ectc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] ACK_NONE   = 2'd3;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_ONE_IN_FOUR,
    READY_HICCUP
  } ready_style_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int           error_count;
  int           results_owed;
  int           burst_left = 0;
  int           beats_sent = 0;
  int           random_base;
  int           pick;
  logic [7:0]   ctrl_b_val;
  ready_style_e ready_style = READY_ALWAYS;
  int           style_left = 0;
  int           ready_phase = 0;

  always #5 clk = ~clk;

  eight_bit_timer_compare_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ectc_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  // Receiver: switch between ready patterns every so often
  always @(negedge clk) begin
    if (style_left == 0) begin
      ready_style = ready_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(20, 200);
    end else begin
      style_left--;
    end
    ready_phase++;
    case (ready_style)
      READY_ALWAYS:      out_tready <= 1'b1;
      READY_COIN:        out_tready <= 1'($urandom_range(0, 1));
      READY_ONE_IN_FOUR: out_tready <= (ready_phase % 4 == 0);
      default:           out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_beat(cmd_e cmd, logic [2:0] idx, logic [7:0] data, logic [1:0] src);
    // idle between bursts; now and then a long burst with no gaps
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, src, data, idx};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    send_beat(CMD_WRITE, idx, data, 2'($urandom));
  endtask

  task automatic read_reg(logic [2:0] idx);
    send_beat(CMD_READ, idx, 8'($urandom), 2'($urandom));
  endtask

  task automatic ack_irq(logic [1:0] src);
    send_beat(CMD_ACK, 3'($urandom), 8'($urandom), src);
  endtask

  task automatic tick_run(int n);
    repeat (n) send_beat(CMD_TICK, 3'($urandom), 8'($urandom), 2'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the unused index, all interrupts unmasked
    read_reg(REG_UNUSED);
    write_reg(REG_UNUSED, 8'hff);
    write_reg(REG_MASK, 8'hff);
    read_reg(REG_MASK);
    // clear on compare A with TOP of 2; both compare flags come up
    write_reg(REG_CMP_A, 8'h02);
    write_reg(REG_CMP_B, 8'h01);
    write_reg(REG_CTRL_A, 8'h02);
    write_reg(REG_CTRL_B, {5'b00000, CS_DIV1});
    tick_run(4);
    read_reg(REG_FLAGS);
    ack_irq(ACK_CMP_A);
    ack_irq(ACK_NONE);
    write_reg(REG_FLAGS, 8'hff);
    // count above TOP runs on to 255 and wraps
    write_reg(REG_COUNT, 8'hfe);
    tick_run(2);
    ack_irq(ACK_OVF);
    // frozen mode, then stopped clock
    write_reg(REG_CTRL_B, 8'h0c);
    tick_run(1);
    write_reg(REG_CTRL_B, 8'h00);
    tick_run(1);
    read_reg(REG_COUNT);

    // slow dividers, once each; clock code 7 acts as the largest divider
    write_reg(REG_CTRL_A, 8'h00);
    write_reg(REG_CTRL_B, {5'b00000, CS_DIV256});
    tick_run(520);
    write_reg(REG_CTRL_B, 8'hf7);
    tick_run(1030);
    read_reg(REG_COUNT);

    random_base = beats_sent;
    while (beats_sent - random_base < 500) begin
      if ($urandom_range(0, 3) != 0) begin
        // set up a mode and clock, then run the timer with some traffic mixed in
        write_reg(REG_CTRL_A, 8'($urandom));
        ctrl_b_val = 8'($urandom);
        pick = $urandom_range(0, 15);
        if (pick < 9) ctrl_b_val[2:0] = CS_DIV1;
        else if (pick < 12) ctrl_b_val[2:0] = CS_DIV8;
        else if (pick == 12) ctrl_b_val[2:0] = CS_DIV64;
        else if (pick == 13) ctrl_b_val[2:0] = CS_STOP;
        else ctrl_b_val[2:0] = 3'($urandom_range(5, 7));
        write_reg(REG_CTRL_B, ctrl_b_val);
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_CMP_A, 8'($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom));
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_CMP_B, 8'($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom));
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_COUNT, 8'($urandom_range(0, 1) ? $urandom_range(248, 255)
                                                       : $urandom_range(0, 16)));
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_MASK, 8'($urandom));
        repeat ($urandom_range(8, 48)) begin
          pick = $urandom_range(0, 15);
          if (pick < 12) tick_run(1);
          else if (pick == 12) read_reg(3'($urandom));
          else if (pick == 13) ack_irq(2'($urandom));
          else if (pick == 14) write_reg(REG_FLAGS, 8'($urandom));
          else write_reg(REG_MASK, 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_beat(cmd_e'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 2'($urandom));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (results_owed == 0);
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
